FILE: sv/rpi_pkg.sv
// Shared types and constants for the ray/plane intersection block.
// No dependencies; used by ray_plane_intersect and its checker.
package rpi_pkg;

    // stream and register port widths
    localparam int unsigned S_DATA_W = 256;
    localparam int unsigned M_DATA_W = 200;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned APB_W    = 32;

    // register indexes, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_PP_X  = 3'd0,
        REG_PP_Y  = 3'd1,
        REG_PP_Z  = 3'd2,
        REG_NRM_X = 3'd3,
        REG_NRM_Y = 3'd4,
        REG_NRM_Z = 3'd5,
        REG_MAT   = 3'd6,
        REG_EPS   = 3'd7
    } t_reg_idx;

    // ray item as carried down the pipeline, packed in s_tdata order
    // (last member lowest; index 0..2 = x..z)
    typedef struct packed {
        logic [31:0]      tmax;
        logic [31:0]      tmin;
        logic [2:0][31:0] dir;
        logic [2:0][31:0] org;
    } t_ray;

    // one divider stage: partial remainder and quotient/dividend shifter
    typedef struct packed {
        logic        vld;
        t_ray        ray;
        logic [51:0] b;
        logic [51:0] rem;
        logic [31:0] q;
        logic        miss;
        logic        neg;
        logic        dneg;
    } t_dstg;

    // result payload, packed in m_tdata order (last member lowest)
    typedef struct packed {
        logic        pad;
        logic [15:0] material;
        logic        front;
        logic [17:0] nz;
        logic [17:0] ny;
        logic [17:0] nx;
        logic [31:0] hz;
        logic [31:0] hy;
        logic [31:0] hx;
        logic [31:0] t;
    } t_res;

endpackage

FILE: sv/ray_plane_intersect.sv
// Ray/plane intersection, fully pipelined, one ray per clock unless the output stalls.
// Depends on rpi_pkg (types, register indexes, port widths).

// Takes one ray per clock on the slave stream and returns one result per ray,
// in order, on the master stream. From input acceptance to m_tvalid a ray
// passes setup (dot products, magnitudes, parallel/range checks), the
// restoring divider that forms t one quotient bit per stage, then sign,
// interval test with the hit-point multipliers, the add/saturate stage and
// the output register. The sustained rate is one item per cycle; s_tready
// drops only once a second finished result is parked in the skid register
// behind an unaccepted output. The plane registers are read live by the
// pipeline, so change them only while no ray is in flight.
module ray_plane_intersect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // ray input: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // t_min, t_max (32 bits each, lowest first)
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rpi_pkg::S_DATA_W-1:0]  i_s_tdata,
    // result: t_hit, hit_x, hit_y, hit_z (32 each), facing_normal_x/y/z
    // (18 each), front_face (1), material_out (16), one zero pad bit
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rpi_pkg::M_DATA_W-1:0]  o_m_tdata,
    // hit_flag
    output logic                          o_m_tuser,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpi_pkg::ADDR_W-1:0]    paddr,
    input  logic [rpi_pkg::APB_W-1:0]     pwdata,
    output logic [rpi_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    // ---------------- plane registers ----------------
    logic signed [31:0] r_pp  [3];
    logic signed [17:0] r_nrm [3];
    logic [15:0]        r_mat;
    logic [15:0]        r_eps;
    logic               w_wr;
    rpi_pkg::t_reg_idx  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = rpi_pkg::t_reg_idx'(paddr[rpi_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp[0]  <= '0;
            r_pp[1]  <= '0;
            r_pp[2]  <= '0;
            r_nrm[0] <= '0;
            r_nrm[1] <= 18'sd65536;
            r_nrm[2] <= '0;
            r_mat    <= '0;
            r_eps    <= 16'd1;
        end else if (w_wr) begin
            unique case (w_idx)
                rpi_pkg::REG_PP_X:  r_pp[0]  <= pwdata;
                rpi_pkg::REG_PP_Y:  r_pp[1]  <= pwdata;
                rpi_pkg::REG_PP_Z:  r_pp[2]  <= pwdata;
                rpi_pkg::REG_NRM_X: r_nrm[0] <= pwdata[17:0];
                rpi_pkg::REG_NRM_Y: r_nrm[1] <= pwdata[17:0];
                rpi_pkg::REG_NRM_Z: r_nrm[2] <= pwdata[17:0];
                rpi_pkg::REG_MAT:   r_mat    <= pwdata[15:0];
                rpi_pkg::REG_EPS:   r_eps    <= pwdata[15:0];
            endcase
        end
    end

    // register readback, normals sign-extended
    always_comb begin
        unique case (w_idx)
            rpi_pkg::REG_PP_X:  prdata = r_pp[0];
            rpi_pkg::REG_PP_Y:  prdata = r_pp[1];
            rpi_pkg::REG_PP_Z:  prdata = r_pp[2];
            rpi_pkg::REG_NRM_X: prdata = {{14{r_nrm[0][17]}}, r_nrm[0]};
            rpi_pkg::REG_NRM_Y: prdata = {{14{r_nrm[1][17]}}, r_nrm[1]};
            rpi_pkg::REG_NRM_Z: prdata = {{14{r_nrm[2][17]}}, r_nrm[2]};
            rpi_pkg::REG_MAT:   prdata = {16'd0, r_mat};
            rpi_pkg::REG_EPS:   prdata = {16'd0, r_eps};
        endcase
    end

    // ---------------- pipeline control ----------------
    // whole pipeline advances unless the output skid register is occupied
    logic r_sv;
    logic w_ce;
    assign w_ce       = ~r_sv;
    assign o_s_tready = w_ce;

    // ---------------- stage 1: capture, point - origin ----------------
    logic               r_v1;
    rpi_pkg::t_ray      r_ray1, n_ray1;
    logic signed [32:0] r_diff1 [3];
    logic signed [32:0] n_diff1 [3];

    always_comb begin
        n_ray1 = i_s_tdata;
        for (int i = 0; i < 3; i++) begin
            n_diff1[i] = {r_pp[i][31], r_pp[i]}
                       - {n_ray1.org[i][31], n_ray1.org[i]};
        end
    end

    // ---------------- stage 2: products ----------------
    logic               r_v2;
    rpi_pkg::t_ray      r_ray2;
    logic signed [49:0] r_pd2 [3];
    logic signed [50:0] r_pn2 [3];
    logic signed [49:0] n_pd2 [3];
    logic signed [50:0] n_pn2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pd2[i] = r_nrm[i] * $signed(r_ray1.dir[i]);
            n_pn2[i] = r_diff1[i] * r_nrm[i];
        end
    end

    // ---------------- stage 3: sums ----------------
    logic               r_v3;
    rpi_pkg::t_ray      r_ray3;
    logic signed [51:0] r_den3, n_den3;
    logic signed [52:0] r_num3, n_num3;

    always_comb begin
        n_den3 = 52'(r_pd2[0]) + 52'(r_pd2[1]) + 52'(r_pd2[2]);
        n_num3 = 53'(r_pn2[0]) + 53'(r_pn2[1]) + 53'(r_pn2[2]);
    end

    // ---------------- stage 4: magnitudes and signs ----------------
    logic          r_v4;
    rpi_pkg::t_ray r_ray4;
    logic [51:0]   r_b4, n_b4;
    logic [52:0]   r_a4, n_a4;
    logic          r_neg4, r_dneg4, n_neg4, n_dneg4;

    always_comb begin
        n_dneg4 = r_den3[51];
        n_b4    = n_dneg4 ? 52'(-r_den3) : 52'(r_den3);
        n_a4    = r_num3[52] ? 53'(-r_num3) : 53'(r_num3);
        n_neg4  = r_num3[52] ^ r_den3[51];
    end

    // ---------------- stage 5 (divider entry): miss checks ----------------
    // parallel when |denom| <= eps (Q20.32); out of range when |t| >= 2^16
    rpi_pkg::t_dstg r_d [0:32];
    rpi_pkg::t_dstg n_d0;

    always_comb begin
        n_d0.vld  = r_v4;
        n_d0.ray  = r_ray4;
        n_d0.b    = r_b4;
        n_d0.rem  = {15'd0, r_a4[52:16]};
        n_d0.q    = {r_a4[15:0], 16'd0};
        n_d0.miss = (r_b4 <= {20'd0, r_eps, 16'd0})
                  | ({15'd0, r_a4[52:16]} >= r_b4);
        n_d0.neg  = r_neg4;
        n_d0.dneg = r_dneg4;
    end

    // front end registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_d[0].vld <= 1'b0;
        end else if (w_ce) begin
            r_v1   <= i_s_tvalid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_d[0] <= n_d0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ray1  <= n_ray1;
            r_diff1 <= n_diff1;
            r_ray2  <= r_ray1;
            r_pd2   <= n_pd2;
            r_pn2   <= n_pn2;
            r_ray3  <= r_ray2;
            r_den3  <= n_den3;
            r_num3  <= n_num3;
            r_ray4  <= r_ray3;
            r_b4    <= n_b4;
            r_a4    <= n_a4;
            r_neg4  <= n_neg4;
            r_dneg4 <= n_dneg4;
        end
    end

    // ---------------- 32 restoring divider stages ----------------
    // each stage shifts in one dividend bit and retires one quotient bit
    for (genvar k = 1; k <= 32; k++) begin : g_div
        rpi_pkg::t_dstg n_d;
        logic [52:0]    w_x;
        logic [52:0]    w_sub;
        logic           w_ge;

        always_comb begin
            w_x     = {r_d[k-1].rem, r_d[k-1].q[31]};
            w_sub   = w_x - {1'b0, r_d[k-1].b};
            w_ge    = (w_x >= {1'b0, r_d[k-1].b});
            n_d     = r_d[k-1];
            n_d.rem = w_ge ? w_sub[51:0] : w_x[51:0];
            n_d.q   = {r_d[k-1].q[30:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[k].vld <= 1'b0;
            end else if (w_ce) begin
                r_d[k] <= n_d;
            end
        end
    end

    // ---------------- stage T1: signed t ----------------
    logic               r_v6;
    rpi_pkg::t_ray      r_ray6;
    logic signed [32:0] r_t6, n_t6;
    logic               r_miss6, r_dneg6;

    assign n_t6 = r_d[32].neg ? -$signed({1'b0, r_d[32].q}) : $signed({1'b0, r_d[32].q});

    // ---------------- stage T2: interval test, dir * t ----------------
    logic               r_v7;
    logic [2:0][31:0]   r_org7;
    logic signed [64:0] r_prod7 [3];
    logic signed [64:0] n_prod7 [3];
    logic [31:0]        r_t7;
    logic               r_hit7, n_hit7, r_dneg7;

    always_comb begin
        n_hit7 = ~r_miss6
               & (r_t6 >= $signed({r_ray6.tmin[31], r_ray6.tmin}))
               & (r_t6 <= $signed({r_ray6.tmax[31], r_ray6.tmax}));
        for (int i = 0; i < 3; i++) begin
            n_prod7[i] = $signed(r_ray6.dir[i]) * r_t6;
        end
    end

    // ---------------- stage T3: hit point, facing normal ----------------
    function automatic logic [31:0] f_sat32(input logic signed [49:0] v);
        logic [31:0] res;
        if (v[49:31] == '0 || v[49:31] == '1) begin
            res = v[31:0];
        end else begin
            res = v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    function automatic logic [17:0] f_face(input logic signed [17:0] n,
                                           input logic dneg);
        logic [17:0] res;
        if (dneg) begin
            res = n;
        end else if (n == 18'sh20000) begin
            res = 18'h1FFFF;
        end else begin
            res = 18'(-n);
        end
        return res;
    endfunction

    logic               r_fv;
    logic               r_fhit, n_fhit;
    rpi_pkg::t_res      r_fres, n_fres;
    logic signed [49:0] w_p [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // floor of the Q32.32 product to Q16.16, then add origin
            w_p[i] = $signed({{18{r_org7[i][31]}}, r_org7[i]})
                   + $signed({r_prod7[i][64], r_prod7[i][64:16]});
        end
        n_fhit = r_hit7;
        n_fres = '0;
        if (r_hit7) begin
            n_fres.t        = r_t7;
            n_fres.hx       = f_sat32(w_p[0]);
            n_fres.hy       = f_sat32(w_p[1]);
            n_fres.hz       = f_sat32(w_p[2]);
            n_fres.nx       = f_face(r_nrm[0], r_dneg7);
            n_fres.ny       = f_face(r_nrm[1], r_dneg7);
            n_fres.nz       = f_face(r_nrm[2], r_dneg7);
            n_fres.front    = r_dneg7;
            n_fres.material = r_mat;
        end
    end

    // back end registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_fv <= 1'b0;
        end else if (w_ce) begin
            r_v6 <= r_d[32].vld;
            r_v7 <= r_v6;
            r_fv <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ray6  <= r_d[32].ray;
            r_t6    <= n_t6;
            r_miss6 <= r_d[32].miss;
            r_dneg6 <= r_d[32].dneg;
            r_org7  <= r_ray6.org;
            r_prod7 <= n_prod7;
            r_t7    <= r_t6[31:0];
            r_hit7  <= n_hit7;
            r_dneg7 <= r_dneg6;
            r_fhit  <= n_fhit;
            r_fres  <= n_fres;
        end
    end

    // ---------------- output register with skid ----------------
    logic          r_ov;
    logic          r_ohit, r_shit;
    rpi_pkg::t_res r_ores, r_sres;
    logic          w_push;
    logic          w_take;

    assign w_push = w_ce & r_fv;
    assign w_take = ~r_ov | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_take) begin
            r_ov <= r_sv | w_push;
            r_sv <= 1'b0;
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ohit <= r_sv ? r_shit : r_fhit;
            r_ores <= r_sv ? r_sres : r_fres;
        end
        if (w_push && !w_take) begin
            r_shit <= r_fhit;
            r_sres <= r_fres;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_ores;
    assign o_m_tuser  = r_ohit;

endmodule

FILE: sv/rpi_chk.sv
// Port-level checker for ray_plane_intersect, attached by bind.
// Depends on rpi_pkg for port widths.
module rpi_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [rpi_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                         o_m_tuser
);

    // a waiting result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result item dropped while stalled");

    // a waiting result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result payload changed while stalled");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss item with nonzero fields");

    // input backpressure only follows a stalled output
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input ready dropped without output stall");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result item offered right after reset");

endmodule

bind ray_plane_intersect rpi_chk u_rpi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
